// ===== hdl/pas_pkg.sv =====
// shared types and constants for the polygon area statistics block
package pas_pkg;

    // field and datapath widths
    localparam int COORD_W      = 16;
    localparam int CNT_W        = 9;
    localparam int MAX_VERTICES = 256;
    localparam int TERM_W       = 2 * COORD_W + 1;
    localparam int ACC_W        = 42;
    localparam int AREA_W       = 40;
    localparam int SUM_W        = 48;
    localparam int TOTAL_W      = 32;
    localparam int MODE_W       = 2;
    localparam int REG_IDX_W    = 1;

    // filter modes
    localparam logic [MODE_W-1:0] FILTER_EVEN  = 2'd0;
    localparam logic [MODE_W-1:0] FILTER_ODD   = 2'd1;
    localparam logic [MODE_W-1:0] FILTER_EXACT = 2'd2;
    localparam logic [MODE_W-1:0] FILTER_ALL   = 2'd3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE     = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_VERTICES = 1'b1;

    // reset values and limits
    localparam logic [CNT_W-1:0] TARGET_RESET = 9'd3;
    localparam logic [CNT_W-1:0] MIN_VERTICES = 9'd3;

    // one input item: a vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_vertex;
    } vertex_t;

    // one result item
    typedef struct packed {
        logic               valid_polygon;
        logic [AREA_W-1:0]  area_doubled;
        logic [SUM_W-1:0]   filtered_sum_doubled;
        logic [TOTAL_W-1:0] matched_count;
        logic [TOTAL_W-1:0] polygon_count;
        logic [AREA_W-1:0]  max_area_doubled;
        logic [AREA_W-1:0]  min_area_doubled;
        logic [CNT_W-1:0]   max_vertex_count;
        logic [CNT_W-1:0]   min_vertex_count;
    } result_t;

    // configuration registers
    typedef struct packed {
        logic [MODE_W-1:0] filter_mode;
        logic [CNT_W-1:0]  target_vertices;
    } cfg_t;

    // cross product terms of one vertex
    typedef struct packed {
        logic signed [TERM_W-1:0] step_term;
        logic signed [TERM_W-1:0] close_term;
        logic                     last_vertex;
        logic [CNT_W-1:0]         vertex_count;
    } term_t;

    // closed polygon: signed shoelace sum and vertex count
    typedef struct packed {
        logic signed [ACC_W-1:0] cross_sum;
        logic [CNT_W-1:0]        vertex_count;
    } closure_t;

    // polygon area with filter decision
    typedef struct packed {
        logic              valid_polygon;
        logic [AREA_W-1:0] area;
        logic [CNT_W-1:0]  vertex_count;
        logic              match;
    } area_info_t;

endpackage

// ===== hdl/polygon_area_statistics.sv =====
// top level of the shoelace polygon area and statistics block
//
// Vertices stream in one item per clock while in_ready is high, with
// last_vertex marking the end of a polygon; every closing vertex yields one
// result item carrying twice the absolute area and the running statistics,
// and other vertices yield none. The datapath is a five-register pipeline
// (input register, cross product terms, shoelace accumulation, area and
// filter, statistics and result), and while the output is not stalled the
// sustained rate is one vertex per cycle, set by the four 16x16 multipliers
// and the 42-bit accumulator of the product and accumulation stages. A
// stalled output holds its result while the stages behind it keep filling.
// Write filter_mode and target_vertices only while no polygon is in flight.
module polygon_area_statistics (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pas_pkg::vertex_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pas_pkg::result_t                  out_data,
    input  logic                              cfg_write,
    input  logic [pas_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [pas_pkg::CNT_W-1:0]         cfg_data
);

    logic [pas_pkg::MODE_W-1:0] filter_mode_reg;
    logic [pas_pkg::CNT_W-1:0]  target_reg;
    pas_pkg::cfg_t              cfg;

    logic                       in_valid_reg;
    pas_pkg::vertex_t           in_item_reg;
    logic                       sl_ready, accept;

    logic                       cl_valid, cl_ready;
    pas_pkg::closure_t          cl_data;
    logic                       ar_valid, ar_ready;
    pas_pkg::area_info_t        ar_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= pas_pkg::FILTER_ALL;
            target_reg      <= pas_pkg::TARGET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pas_pkg::REG_FILTER_MODE:
                    filter_mode_reg <= cfg_data[pas_pkg::MODE_W-1:0];
                pas_pkg::REG_TARGET_VERTICES:
                    target_reg <= cfg_data;
            endcase
        end
    end

    assign cfg.filter_mode     = filter_mode_reg;
    assign cfg.target_vertices = target_reg;

    // input register
    assign in_ready = !in_valid_reg || sl_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !sl_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
    end

    // shoelace accumulation
    pas_shoelace u_shoelace (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (sl_ready),
        .in_data   (in_item_reg),
        .out_valid (cl_valid),
        .out_ready (cl_ready),
        .out_data  (cl_data)
    );

    // area and filter
    pas_area u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (cl_valid),
        .in_ready  (cl_ready),
        .in_data   (cl_data),
        .out_valid (ar_valid),
        .out_ready (ar_ready),
        .out_data  (ar_data)
    );

    // statistics and result register
    pas_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ar_valid),
        .in_ready  (ar_ready),
        .in_data   (ar_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // short polygons carry no area
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_polygon |-> out_data.area_doubled == '0)
    else $error("short polygon with nonzero area");

    // a counted polygon lies within the running area extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_polygon |->
            out_data.min_area_doubled <= out_data.area_doubled &&
            out_data.area_doubled <= out_data.max_area_doubled)
    else $error("area outside running extremes");

    // vertex count extremes of counted polygons stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_polygon |->
            out_data.min_vertex_count >= pas_pkg::MIN_VERTICES &&
            out_data.min_vertex_count <= out_data.max_vertex_count &&
            out_data.max_vertex_count <= pas_pkg::CNT_W'(pas_pkg::MAX_VERTICES))
    else $error("vertex count extremes out of range");

    // matched polygons are a subset of counted polygons
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.matched_count <= out_data.polygon_count)
    else $error("matched count exceeds polygon count");

endmodule

// ===== hdl/pas_shoelace.sv =====
// vertex tracking, cross product terms and shoelace accumulation
module pas_shoelace (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pas_pkg::vertex_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pas_pkg::closure_t   out_data
);

    localparam int COORD_W = pas_pkg::COORD_W;
    localparam int CNT_W   = pas_pkg::CNT_W;
    localparam int TERM_W  = pas_pkg::TERM_W;
    localparam int ACC_W   = pas_pkg::ACC_W;

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]          count_reg, count_next, count_inc;
    logic                      term_valid_reg;
    pas_pkg::term_t            term_reg, term_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    pas_pkg::closure_t         closure_reg, closure_next;

    logic                      accept, term_take, take, has_prev;
    logic signed [COORD_W-1:0] cur_x, cur_y, first_cur_x, first_cur_y;
    logic signed [2*COORD_W-1:0] step_a, step_b, close_a, close_b;

    // handshake: product stage drains into the closure register
    assign term_take = term_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !term_valid_reg || term_take;
    assign accept    = in_valid && in_ready;

    // vertex bookkeeping, vertices past the limit are dropped
    assign take        = count_reg < CNT_W'(pas_pkg::MAX_VERTICES);
    assign has_prev    = count_reg != '0;
    assign cur_x       = take ? in_data.x_coord : prev_x_reg;
    assign cur_y       = take ? in_data.y_coord : prev_y_reg;
    assign first_cur_x = (take && !has_prev) ? in_data.x_coord : first_x_reg;
    assign first_cur_y = (take && !has_prev) ? in_data.y_coord : first_y_reg;
    assign count_inc   = take ? count_reg + CNT_W'(1) : count_reg;
    assign count_next  = in_data.last_vertex ? '0 : count_inc;

    // edge term from previous vertex and closing term back to the first
    assign step_a  = prev_x_reg * in_data.y_coord;
    assign step_b  = prev_y_reg * in_data.x_coord;
    assign close_a = cur_x * first_cur_y;
    assign close_b = cur_y * first_cur_x;

    always_comb
    begin
        term_next.step_term    = (take && has_prev) ?
                                 TERM_W'(step_a) - TERM_W'(step_b) : '0;
        term_next.close_term   = TERM_W'(close_a) - TERM_W'(close_b);
        term_next.last_vertex  = in_data.last_vertex;
        term_next.vertex_count = count_inc;
    end

    // accumulation, the range of 16-bit vertices keeps the sum far from overflow
    always_comb
    begin
        acc_next                  = acc_reg;
        closure_next              = closure_reg;
        out_valid_next            = out_valid_reg && !out_ready;
        closure_next.cross_sum    = acc_reg + ACC_W'(term_reg.step_term)
                                    + ACC_W'(term_reg.close_term);
        closure_next.vertex_count = term_reg.vertex_count;
        if (term_take)
        begin
            if (term_reg.last_vertex)
            begin
                acc_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(term_reg.step_term);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            term_valid_reg <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            term_valid_reg <= accept || (term_valid_reg && !term_take);
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // vertex and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (take)
            begin
                prev_x_reg <= in_data.x_coord;
                prev_y_reg <= in_data.y_coord;
            end
            first_x_reg <= first_cur_x;
            first_y_reg <= first_cur_y;
            term_reg    <= term_next;
        end
        if (term_take && term_reg.last_vertex)
        begin
            closure_reg <= closure_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = closure_reg;

endmodule

// ===== hdl/pas_area.sv =====
// absolute doubled area, validity and filter match of a closed polygon
module pas_area (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pas_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pas_pkg::closure_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pas_pkg::area_info_t  out_data
);

    localparam int ACC_W  = pas_pkg::ACC_W;
    localparam int AREA_W = pas_pkg::AREA_W;

    logic                 valid_reg;
    pas_pkg::area_info_t  info_reg, info_next;
    logic [ACC_W-1:0]     abs_sum;
    logic [AREA_W-1:0]    area_sat;
    logic                 accept, match;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // magnitude with saturation to the area width
    assign abs_sum  = in_data.cross_sum[ACC_W-1] ? ACC_W'(-in_data.cross_sum)
                                                  : ACC_W'(in_data.cross_sum);
    assign area_sat = (|abs_sum[ACC_W-1:AREA_W]) ? '1 : abs_sum[AREA_W-1:0];

    // filter decision
    always_comb
    begin
        unique case (cfg.filter_mode)
            pas_pkg::FILTER_EVEN:  match = !in_data.vertex_count[0];
            pas_pkg::FILTER_ODD:   match = in_data.vertex_count[0];
            pas_pkg::FILTER_EXACT: match = in_data.vertex_count == cfg.target_vertices;
            pas_pkg::FILTER_ALL:   match = 1'b1;
        endcase
    end

    always_comb
    begin
        info_next.valid_polygon = in_data.vertex_count >= pas_pkg::MIN_VERTICES;
        info_next.area          = info_next.valid_polygon ? area_sat : '0;
        info_next.vertex_count  = in_data.vertex_count;
        info_next.match         = match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept || (valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            info_reg <= info_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = info_reg;

endmodule

// ===== hdl/pas_stats.sv =====
// running statistics and result register
module pas_stats (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pas_pkg::area_info_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pas_pkg::result_t     out_data
);

    localparam int AREA_W  = pas_pkg::AREA_W;
    localparam int SUM_W   = pas_pkg::SUM_W;
    localparam int TOTAL_W = pas_pkg::TOTAL_W;
    localparam int CNT_W   = pas_pkg::CNT_W;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TOTAL_W-1:0] matched_reg, matched_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [AREA_W-1:0]  max_area_reg, max_area_next;
    logic [AREA_W-1:0]  min_area_reg, min_area_next;
    logic [CNT_W-1:0]   max_cnt_reg, max_cnt_next;
    logic [CNT_W-1:0]   min_cnt_reg, min_cnt_next;
    logic               out_valid_reg;
    pas_pkg::result_t   result_reg, result_next;

    logic [SUM_W:0]     sum_wide;
    logic               accept, upd, upd_match;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign upd       = in_data.valid_polygon;
    assign upd_match = upd && in_data.match;

    // saturating filtered sum and counts
    assign sum_wide     = {1'b0, sum_reg} + {{(SUM_W + 1 - AREA_W){1'b0}}, in_data.area};
    assign sum_next     = !upd_match ? sum_reg :
                          (sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0]);
    assign matched_next = (upd_match && !(&matched_reg)) ?
                          matched_reg + TOTAL_W'(1) : matched_reg;
    assign total_next   = (upd && !(&total_reg)) ? total_reg + TOTAL_W'(1) : total_reg;

    // extremes of area and vertex count
    assign max_area_next = (upd && in_data.area > max_area_reg) ? in_data.area : max_area_reg;
    assign min_area_next = (upd && in_data.area < min_area_reg) ? in_data.area : min_area_reg;
    assign max_cnt_next  = (upd && in_data.vertex_count > max_cnt_reg) ?
                           in_data.vertex_count : max_cnt_reg;
    assign min_cnt_next  = (upd && in_data.vertex_count < min_cnt_reg) ?
                           in_data.vertex_count : min_cnt_reg;

    always_comb
    begin
        result_next.valid_polygon        = in_data.valid_polygon;
        result_next.area_doubled         = in_data.area;
        result_next.filtered_sum_doubled = sum_next;
        result_next.matched_count        = matched_next;
        result_next.polygon_count        = total_next;
        result_next.max_area_doubled     = max_area_next;
        result_next.min_area_doubled     = min_area_next;
        result_next.max_vertex_count     = max_cnt_next;
        result_next.min_vertex_count     = min_cnt_next;
    end

    // statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            matched_reg   <= '0;
            total_reg     <= '0;
            max_area_reg  <= '0;
            min_area_reg  <= '1;
            max_cnt_reg   <= '0;
            min_cnt_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sum_reg      <= sum_next;
                matched_reg  <= matched_next;
                total_reg    <= total_next;
                max_area_reg <= max_area_next;
                min_area_reg <= min_area_next;
                max_cnt_reg  <= max_cnt_next;
                min_cnt_reg  <= min_cnt_next;
            end
            out_valid_reg <= accept || (out_valid_reg && !out_ready);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule

// ===== verif/polygon_area_checker.sv =====
// checker for the polygon area block: predicts each closing result and compares it
module polygon_area_checker
    import pas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  vertex_t              in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  result_t              out_data,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   results_waiting,
    output int                   results_seen
);

    localparam longint          CROSS_LIMIT = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint unsigned AREA_CAP    = (64'd1 << AREA_W) - 1;
    localparam longint unsigned SUM_CAP     = (64'd1 << SUM_W) - 1;
    localparam longint unsigned TOTAL_CAP   = (64'd1 << TOTAL_W) - 1;
    localparam longint unsigned COUNT_CAP   = (64'd1 << CNT_W) - 1;

    // register copies
    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  target_reg;

    // open polygon
    longint first_x, first_y, prev_x, prev_y;
    longint cross_sum;
    int     held;

    // running statistics
    longint unsigned area_sum, matched, polygons;
    longint unsigned top_area, bottom_area, top_count, bottom_count;

    result_t expected_results[$];

    function automatic longint clamp_cross(longint s);
        if (s > CROSS_LIMIT)
            return CROSS_LIMIT;
        if (s < -CROSS_LIMIT)
            return -CROSS_LIMIT;
        return s;
    endfunction

    function automatic longint unsigned capped_add(longint unsigned a, longint unsigned b,
                                                   longint unsigned cap);
        if (a >= cap || b >= cap - a)
            return cap;
        return a + b;
    endfunction

    // one shoelace term, a.x*b.y - a.y*b.x, each half clamped
    task automatic add_edge(longint ax, longint ay, longint bx, longint by);
        cross_sum = clamp_cross(cross_sum + ax * by);
        cross_sum = clamp_cross(cross_sum - ay * bx);
    endtask

    task automatic clear_model();
        mode_reg       = FILTER_ALL;
        target_reg     = TARGET_RESET;
        first_x        = 0;
        first_y        = 0;
        prev_x         = 0;
        prev_y         = 0;
        cross_sum      = 0;
        held           = 0;
        area_sum       = 0;
        matched        = 0;
        polygons       = 0;
        top_area       = 0;
        bottom_area    = AREA_CAP;
        top_count      = 0;
        bottom_count   = COUNT_CAP;
        mismatch_count = 0;
        results_seen   = 0;
        expected_results.delete();
    endtask

    // fold one vertex into the open polygon; a closing vertex yields a result
    task automatic fold_vertex(vertex_t v);
        longint          x;
        longint          y;
        longint unsigned area;
        logic            hit;
        result_t         r;
        x = longint'(v.x_coord);
        y = longint'(v.y_coord);
        // vertices past the limit are dropped
        if (held < MAX_VERTICES)
        begin
            if (held == 0)
            begin
                first_x = x;
                first_y = y;
            end
            else
                add_edge(prev_x, prev_y, x, y);
            prev_x = x;
            prev_y = y;
            held++;
        end
        if (v.last_vertex)
        begin
            add_edge(prev_x, prev_y, first_x, first_y);
            area = 0;
            if (held >= MIN_VERTICES)
            begin
                area = (cross_sum < 0) ? -cross_sum : cross_sum;
                if (area > AREA_CAP)
                    area = AREA_CAP;
                case (mode_reg)
                    FILTER_EVEN:  hit = (held % 2 == 0);
                    FILTER_ODD:   hit = (held % 2 == 1);
                    FILTER_EXACT: hit = (held == target_reg);
                    default:      hit = 1'b1;
                endcase
                if (hit)
                begin
                    area_sum = capped_add(area_sum, area, SUM_CAP);
                    matched  = capped_add(matched, 64'd1, TOTAL_CAP);
                end
                polygons = capped_add(polygons, 64'd1, TOTAL_CAP);
                if (area > top_area)
                    top_area = area;
                if (area < bottom_area)
                    bottom_area = area;
                if (held > top_count)
                    top_count = 64'(held);
                if (held < bottom_count)
                    bottom_count = 64'(held);
            end
            r.valid_polygon        = (held >= MIN_VERTICES);
            r.area_doubled         = AREA_W'(area);
            r.filtered_sum_doubled = SUM_W'(area_sum);
            r.matched_count        = TOTAL_W'(matched);
            r.polygon_count        = TOTAL_W'(polygons);
            r.max_area_doubled     = AREA_W'(top_area);
            r.min_area_doubled     = AREA_W'(bottom_area);
            r.max_vertex_count     = CNT_W'(top_count);
            r.min_vertex_count     = CNT_W'(bottom_count);
            expected_results = {expected_results, r};
            cross_sum = 0;
            held      = 0;
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // compare one accepted result with the oldest prediction
    task automatic check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result item with no polygon closed");
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("valid_polygon", 64'(want.valid_polygon), 64'(got.valid_polygon));
            check_field("area_doubled", 64'(want.area_doubled), 64'(got.area_doubled));
            check_field("filtered_sum_doubled", 64'(want.filtered_sum_doubled),
                        64'(got.filtered_sum_doubled));
            check_field("matched_count", 64'(want.matched_count), 64'(got.matched_count));
            check_field("polygon_count", 64'(want.polygon_count), 64'(got.polygon_count));
            check_field("max_area_doubled", 64'(want.max_area_doubled),
                        64'(got.max_area_doubled));
            check_field("min_area_doubled", 64'(want.min_area_doubled),
                        64'(got.min_area_doubled));
            check_field("max_vertex_count", 64'(want.max_vertex_count),
                        64'(got.max_vertex_count));
            check_field("min_vertex_count", 64'(want.min_vertex_count),
                        64'(got.min_vertex_count));
        end
        results_seen++;
    endtask

    // watch the channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_FILTER_MODE)
                    mode_reg = cfg_data[MODE_W-1:0];
                else if (cfg_index == REG_TARGET_VERTICES)
                    target_reg = cfg_data;
            end
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                fold_vertex(in_data);
        end
        results_waiting = expected_results.size();
    end

endmodule

// ===== verif/polygon_area_statistics_test.sv =====
// testbench top for the polygon area block: stimulus, idling and verdict
module polygon_area_statistics_test;
    import pas_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_GAP      = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    vertex_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    result_t              out_data;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    int mismatch_count;
    int results_waiting;
    int results_seen;
    int vertices_sent;
    int settings_used;
    int idle_cycles = 0;
    bit calm;

    polygon_area_statistics i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    polygon_area_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting),
        .results_seen    (results_seen)
    );

    // clock
    initial
        clk = 1'b0;
    always #2 clk = ~clk;

    // gap or stall length for one item; calm stretches have none
    function automatic int pick_gap();
        if (calm)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(bit wide);
        if (wide)
            return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 400)) - COORD_W'(200);
    endfunction

    // present one vertex after a random gap and hold it until accepted
    task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
        vertex_t v;
        int      gap;
        v.x_coord     = x;
        v.y_coord     = y;
        v.last_vertex = last;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (!in_ready);
        vertices_sent++;
    endtask

    task automatic send_polygon(int n, bit wide);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(wide), pick_coord(wide), i == n - 1);
    endtask

    // let every closed polygon come out, then the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // write both registers while the block is idle
    task automatic write_settings(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] target);
        settle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= {(CNT_W - MODE_W)'($urandom), mode};
        @(negedge clk);
        cfg_index <= REG_TARGET_VERTICES;
        cfg_data  <= target;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // random polygons, mostly small, some too short to count
    task automatic random_polygons(int budget);
        int start;
        int pick;
        int n;
        start = vertices_sent;
        while (vertices_sent - start < budget)
        begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = 1;
            else if (pick == 1)
                n = 2;
            else
                n = $urandom_range(3, 12);
            send_polygon(n, $urandom_range(0, 1) == 1);
        end
    endtask

    // result side: a random stall before each item
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [MODE_W-1:0] phase_mode [7];
        logic [CNT_W-1:0]  phase_target [7];
        phase_mode   = '{FILTER_EVEN, FILTER_ODD, FILTER_EXACT, FILTER_EXACT,
                         FILTER_EXACT, FILTER_EXACT, FILTER_ALL};
        phase_target = '{9'd5, 9'd511, 9'd3, 9'd0, 9'd4, 9'd2, 9'd257};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_write     = 1'b0;
        cfg_index     = REG_FILTER_MODE;
        cfg_data      = '0;
        vertices_sent = 0;
        settings_used = 0;
        calm          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: short polygons first, then extremes, under reset settings
        send_vertex(16'h7fff, 16'h8000, 1'b1);
        send_vertex(16'h8000, 16'h7fff, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b1);
        // triangle across the full range, counterclockwise
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7fff, 16'h8000, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b1);
        // full range square, clockwise
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h8000, 16'h7fff, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b0);
        send_vertex(16'h7fff, 16'h8000, 1'b1);
        // collinear triangle, zero area
        send_vertex(16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0001, 16'h0001, 1'b0);
        send_vertex(16'hffff, 16'hffff, 1'b1);
        // small clockwise triangle
        send_vertex(16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h0000, 16'h0001, 1'b0);
        send_vertex(16'h0001, 16'h0000, 1'b1);
        // pentagon
        send_vertex(16'h0005, 16'h0000, 1'b0);
        send_vertex(16'h0002, 16'h0004, 1'b0);
        send_vertex(16'hfffc, 16'h0002, 1'b0);
        send_vertex(16'hfffc, 16'hfffe, 1'b0);
        send_vertex(16'h0002, 16'hfffc, 1'b1);

        // random phases over filter settings
        for (int k = 0; k < 7; k++)
        begin
            write_settings(phase_mode[k], phase_target[k]);
            random_polygons(45);
        end

        // one polygon past the vertex limit, held at the largest count
        write_settings(FILTER_EXACT, 9'd256);
        calm = 1'b0;
        send_polygon(MAX_VERTICES + 4, 1'b1);
        send_polygon(3, 1'b1);
        write_settings(FILTER_ALL, 9'd3);
        random_polygons(20);

        settle();
        $display("sent %0d vertices, checked %0d polygon results", vertices_sent,
                 results_seen);
        $display("over %0d register settings with random gaps on both channels",
                 settings_used);
        if (mismatch_count == 0 && results_waiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
